/* rtl/wdt_pkg.sv */
// wdt_pkg: shared widths and register codes for the wide divisibility test
// no dependencies
`default_nettype none
package wdt_pkg;
    localparam int WORD_W       = 32;
    localparam int MAX_WORDS    = 8;
    localparam int MAX_BITS     = WORD_W * MAX_WORDS;
    localparam int FIELD_W      = 64;
    localparam int COL_GROW     = 4;
    localparam int CFG_IDX_W    = 3;
    localparam int DEF_CONST_WORDS = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAGIC_W0,
        REG_MAGIC_W1,
        REG_MAGIC_W2,
        REG_MAGIC_W3,
        REG_BOUND_W0,
        REG_BOUND_W1,
        REG_BOUND_W2,
        REG_BOUND_W3
    } cfg_reg_t;
endpackage
`default_nettype wire

/* rtl/wide_divisibility_test.sv */
// wide_divisibility_test: top level, config registers and pipeline valid chain
// depends on wdt_pkg, wdt_mul_stage, wdt_col_stage, wdt_final_stage
//
// usage
// - input channel in_valid/in_ready carries one 256-bit candidate per item
//   as cand_w0 (least significant) to cand_w3
// - output channel out_valid/out_ready returns is_divisible, one per item,
//   in order
// - config: cfg_write with cfg_index and cfg_wdata writes a 64-bit word,
//   indexes 0-3 magic constant, 4-7 bound; write only while idle
// - out_valid rises once the item has passed the four register stages
//   (multiply, column sum, carry resolve, compare), all advancing together;
//   one item per cycle sustained while the receiver does not stall a
//   waiting result
// - when the receiver stalls with a result waiting the whole pipeline holds
//   and in_ready drops; nothing is lost or repeated
// - reset clears the valid chain and all config registers to zero
`default_nettype none
module wide_divisibility_test #(
    parameter int CONST_WORDS = wdt_pkg::DEF_CONST_WORDS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [wdt_pkg::FIELD_W-1:0]     cand_w0,
    input  wire logic [wdt_pkg::FIELD_W-1:0]     cand_w1,
    input  wire logic [wdt_pkg::FIELD_W-1:0]     cand_w2,
    input  wire logic [wdt_pkg::FIELD_W-1:0]     cand_w3,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic                                 is_divisible,
    input  wire logic                            cfg_write,
    input  wire logic [wdt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [wdt_pkg::FIELD_W-1:0]     cfg_wdata
);
    import wdt_pkg::*;

    // word count held to the supported range
    localparam int KW     = (CONST_WORDS < 1) ? 1 :
                            ((CONST_WORDS > MAX_WORDS) ? MAX_WORDS : CONST_WORDS);
    localparam int PW     = KW * WORD_W;
    localparam int STAGES = 4;

    logic [MAX_BITS-1:0] magic_reg;
    logic [MAX_BITS-1:0] bound_reg;
    logic [MAX_BITS-1:0] cand_all;
    logic [STAGES-1:0]   valid_reg;
    logic                en;

    logic [KW-1:0][KW-1:0][2*WORD_W-1:0] pp;
    logic [KW-1:0][WORD_W+COL_GROW-1:0]  col;

    assign cand_all  = {cand_w3, cand_w2, cand_w1, cand_w0};
    assign en        = !valid_reg[STAGES-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = valid_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg <= '0;
            bound_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MAGIC_W0: magic_reg[0*FIELD_W +: FIELD_W] <= cfg_wdata;
                REG_MAGIC_W1: magic_reg[1*FIELD_W +: FIELD_W] <= cfg_wdata;
                REG_MAGIC_W2: magic_reg[2*FIELD_W +: FIELD_W] <= cfg_wdata;
                REG_MAGIC_W3: magic_reg[3*FIELD_W +: FIELD_W] <= cfg_wdata;
                REG_BOUND_W0: bound_reg[0*FIELD_W +: FIELD_W] <= cfg_wdata;
                REG_BOUND_W1: bound_reg[1*FIELD_W +: FIELD_W] <= cfg_wdata;
                REG_BOUND_W2: bound_reg[2*FIELD_W +: FIELD_W] <= cfg_wdata;
                REG_BOUND_W3: bound_reg[3*FIELD_W +: FIELD_W] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
        end
    end

    wdt_mul_stage #(.K(KW)) u_mul (
        .clk   (clk),
        .en    (en),
        .cand  (cand_all[PW-1:0]),
        .magic (magic_reg[PW-1:0]),
        .pp    (pp)
    );

    wdt_col_stage #(.K(KW)) u_col (
        .clk (clk),
        .en  (en),
        .pp  (pp),
        .col (col)
    );

    wdt_final_stage #(.K(KW)) u_fin (
        .clk    (clk),
        .en     (en),
        .col    (col),
        .bound  (bound_reg[PW-1:0]),
        .is_div (is_divisible)
    );
endmodule
`default_nettype wire

/* rtl/wdt_mul_stage.sv */
// wdt_mul_stage: registered 32x32 partial products of the truncated product
// depends on wdt_pkg
`default_nettype none
module wdt_mul_stage #(
    parameter int K = wdt_pkg::DEF_CONST_WORDS
) (
    input  wire logic                                    clk,
    input  wire logic                                    en,
    input  wire logic [K*wdt_pkg::WORD_W-1:0]            cand,
    input  wire logic [K*wdt_pkg::WORD_W-1:0]            magic,
    output logic [K-1:0][K-1:0][2*wdt_pkg::WORD_W-1:0]   pp
);
    import wdt_pkg::*;

    logic [K-1:0][K-1:0][2*WORD_W-1:0] pp_reg;
    logic [K-1:0][K-1:0][2*WORD_W-1:0] pp_next;

    always_comb
    begin
        for (int i = 0; i < K; i++)
        begin
            for (int j = 0; j < K; j++)
            begin
                if (i + j < K)
                begin
                    pp_next[i][j] = cand[i*WORD_W +: WORD_W] * magic[j*WORD_W +: WORD_W];
                end
                else
                begin
                    pp_next[i][j] = '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_reg <= pp_next;
        end
    end

    assign pp = pp_reg;
endmodule
`default_nettype wire

/* rtl/wdt_col_stage.sv */
// wdt_col_stage: column sums of the partial product halves
// depends on wdt_pkg
`default_nettype none
module wdt_col_stage #(
    parameter int K = wdt_pkg::DEF_CONST_WORDS
) (
    input  wire logic                                           clk,
    input  wire logic                                           en,
    input  wire logic [K-1:0][K-1:0][2*wdt_pkg::WORD_W-1:0]     pp,
    output logic [K-1:0][wdt_pkg::WORD_W+wdt_pkg::COL_GROW-1:0] col
);
    import wdt_pkg::*;

    logic [K-1:0][WORD_W+COL_GROW-1:0] col_reg;
    logic [K-1:0][WORD_W+COL_GROW-1:0] col_next;

    always_comb
    begin
        for (int c = 0; c < K; c++)
        begin
            col_next[c] = '0;
            for (int i = 0; i < K; i++)
            begin
                for (int j = 0; j < K; j++)
                begin
                    if (i + j == c)
                    begin
                        col_next[c] = col_next[c]
                                    + {{COL_GROW{1'b0}}, pp[i][j][WORD_W-1:0]};
                    end
                    else if (i + j + 1 == c)
                    begin
                        col_next[c] = col_next[c]
                                    + {{COL_GROW{1'b0}}, pp[i][j][2*WORD_W-1:WORD_W]};
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col_reg <= col_next;
        end
    end

    assign col = col_reg;
endmodule
`default_nettype wire

/* rtl/wdt_final_stage.sv */
// wdt_final_stage: carry resolve into the truncated product, then bound compare
// depends on wdt_pkg
`default_nettype none
module wdt_final_stage #(
    parameter int K = wdt_pkg::DEF_CONST_WORDS
) (
    input  wire logic                                           clk,
    input  wire logic                                           en,
    input  wire logic [K-1:0][wdt_pkg::WORD_W+wdt_pkg::COL_GROW-1:0] col,
    input  wire logic [K*wdt_pkg::WORD_W-1:0]                   bound,
    output logic                                                is_div
);
    import wdt_pkg::*;

    localparam int PW = K * WORD_W;

    logic [PW-1:0] lo_vec;
    logic [PW-1:0] hi_vec;
    logic [PW-1:0] prod_next;
    logic [PW-1:0] prod_reg;
    logic          div_next;
    logic          div_reg;

    always_comb
    begin
        lo_vec = '0;
        hi_vec = '0;
        for (int c = 0; c < K; c++)
        begin
            lo_vec[c*WORD_W +: WORD_W] = col[c][WORD_W-1:0];
            if (c + 1 < K)
            begin
                hi_vec[(c+1)*WORD_W +: COL_GROW] = col[c][WORD_W+COL_GROW-1:WORD_W];
            end
        end
        prod_next = lo_vec + hi_vec;
        div_next  = (prod_reg <= bound);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            div_reg  <= div_next;
        end
    end

    assign is_div = div_reg;
endmodule
`default_nettype wire

/* rtl/wdt_checker.sv */
// wdt_checker: port-level checks for wide_divisibility_test, bound to the top
// depends on wide_divisibility_test ports only
`default_nettype none
module wdt_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic is_divisible
);
    // a held result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(is_divisible))
        else $error("result changed while stalled");

    // input is only blocked by a stalled result
    a_ready_tie: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready not tied to output stall");

    // an accepted item is offered once it has passed the pipeline, while the output stays free
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready ##1 out_ready
        |=> out_valid)
        else $error("item not delivered in time");

    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown(is_divisible))
        else $error("result unknown");
endmodule

bind wide_divisibility_test wdt_checker u_wdt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .is_divisible (is_divisible)
);
`default_nettype wire
